// ----- hdl/bpc_pkg.sv -----
// Shared types and constants for the button press classifier.
package bpc_pkg;

  localparam int unsigned TICK_W = 14;
  localparam int unsigned CODE_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0] HOLD_SAT = 14'd10000;

  // phase codes
  localparam logic [CODE_W-1:0] PH_WAIT_PRESS      = 2'd0;
  localparam logic [CODE_W-1:0] PH_WAIT_RELEASE    = 2'd1;
  localparam logic [CODE_W-1:0] PH_WAIT_CONTINUOUS = 2'd2;

  // event codes
  localparam logic [CODE_W-1:0] EV_NONE       = 2'd0;
  localparam logic [CODE_W-1:0] EV_SHORT      = 2'd1;
  localparam logic [CODE_W-1:0] EV_LONG       = 2'd2;
  localparam logic [CODE_W-1:0] EV_CONTINUOUS = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS = 2'd2;

  localparam logic [TICK_W-1:0] DEBOUNCE_RST   = 14'd50;
  localparam logic [TICK_W-1:0] LONG_PRESS_RST = 14'd1000;
  localparam logic [TICK_W-1:0] CONTINUOUS_RST = 14'd2000;

  typedef struct packed {
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] long_press_ticks;
    logic [TICK_W-1:0] continuous_ticks;
  } cfg_t;

endpackage

// ----- hdl/bpc_cfg_regs.sv -----
// Threshold configuration registers.
module bpc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpc_pkg::TICK_W-1:0]         cfg_wr_data,
  output bpc_pkg::cfg_t                      cfg
);

  bpc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= bpc_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ticks <= bpc_pkg::LONG_PRESS_RST;
      cfg_r.continuous_ticks <= bpc_pkg::CONTINUOUS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bpc_pkg::REG_DEBOUNCE:   cfg_r.debounce_ticks   <= cfg_wr_data;
        bpc_pkg::REG_LONG_PRESS: cfg_r.long_press_ticks <= cfg_wr_data;
        bpc_pkg::REG_CONTINUOUS: cfg_r.continuous_ticks <= cfg_wr_data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/bpc_core.sv -----
// Hold counter, press phase machine and pending event register.
module bpc_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          button_level,
  input  logic                          take_event,
  input  bpc_pkg::cfg_t                 cfg,
  output logic [bpc_pkg::CODE_W-1:0]    event_code,
  output logic [bpc_pkg::CODE_W-1:0]    fsm_phase
);

  logic [bpc_pkg::CODE_W-1:0] phase_r, phase_nxt;
  logic [bpc_pkg::TICK_W-1:0] hold_r, hold_nxt, hold_inc;
  logic [bpc_pkg::CODE_W-1:0] pending_r, pending_nxt, ev_upd;

  always_comb begin
    hold_inc  = (hold_r < bpc_pkg::HOLD_SAT) ? hold_r + 14'd1 : hold_r;
    hold_nxt  = hold_inc;
    phase_nxt = phase_r;
    ev_upd    = pending_r;
    case (phase_r)
      bpc_pkg::PH_WAIT_RELEASE: begin
        if (!button_level) begin
          ev_upd    = (hold_inc < cfg.long_press_ticks) ? bpc_pkg::EV_SHORT
                                                        : bpc_pkg::EV_LONG;
          phase_nxt = bpc_pkg::PH_WAIT_PRESS;
          hold_nxt  = '0;
        end else if (hold_inc >= cfg.continuous_ticks) begin
          ev_upd    = bpc_pkg::EV_CONTINUOUS;
          phase_nxt = bpc_pkg::PH_WAIT_CONTINUOUS;
        end
      end
      bpc_pkg::PH_WAIT_CONTINUOUS: begin
        if (!button_level) begin
          phase_nxt = bpc_pkg::PH_WAIT_PRESS;
          hold_nxt  = '0;
        end
      end
      default: begin
        // wait press; unused code falls back here too
        phase_nxt = bpc_pkg::PH_WAIT_PRESS;
        if (button_level && pending_r == bpc_pkg::EV_NONE) begin
          if (hold_inc >= cfg.debounce_ticks) begin
            hold_nxt  = '0;
            phase_nxt = bpc_pkg::PH_WAIT_RELEASE;
          end
        end else begin
          hold_nxt = '0;
        end
      end
    endcase
    pending_nxt = take_event ? bpc_pkg::EV_NONE : ev_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= bpc_pkg::PH_WAIT_PRESS;
      hold_r    <= '0;
      pending_r <= bpc_pkg::EV_NONE;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      hold_r    <= hold_nxt;
      pending_r <= pending_nxt;
    end
  end

  assign event_code = ev_upd;
  assign fsm_phase  = phase_nxt;

`ifndef ASSERT_OFF
  a_hold_sat: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r <= bpc_pkg::HOLD_SAT)
    else $error("hold counter above saturation");

  a_blocked_press: assert property (@(posedge clk) disable iff (!rst_n)
    adv && phase_r == bpc_pkg::PH_WAIT_PRESS && pending_r != bpc_pkg::EV_NONE
    |=> hold_r == '0 && phase_r == bpc_pkg::PH_WAIT_PRESS)
    else $error("press accepted while an event was pending");

  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && take_event |=> pending_r == bpc_pkg::EV_NONE)
    else $error("pending event not cleared on read");
`endif

endmodule

// ----- hdl/button_press_classifier.sv -----
// Button press classifier: one tick transaction in, one event/phase result out.
// Stages: input register, then result register (state updates as the item enters
//   the result register).
// Throughput: one transaction per cycle while the output is not stalled.
// Reset (synchronous, rst_n low): phase wait press, hold count 0, no event
//   pending, thresholds 50 / 1000 / 2000 ticks, both pipeline stages empty.
module button_press_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_button_level,
  input  logic                              in_take_event,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bpc_pkg::CODE_W-1:0]        out_event_code,
  output logic [bpc_pkg::CODE_W-1:0]        out_fsm_phase,
  input  logic                              cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::TICK_W-1:0]        cfg_wr_data
);

  bpc_pkg::cfg_t cfg;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_level_r, s1_take_r;
  logic out_valid_r, out_valid_nxt;
  logic [bpc_pkg::CODE_W-1:0] out_event_r, out_phase_r;
  logic [bpc_pkg::CODE_W-1:0] ev_code, ph_code;
  logic in_acc, adv;

  bpc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  bpc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .button_level (s1_level_r),
    .take_event   (s1_take_r),
    .cfg          (cfg),
    .event_code   (ev_code),
    .fsm_phase    (ph_code)
  );

  // staged item moves to the result register when that slot is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_level_r <= in_button_level;
      s1_take_r  <= in_take_event;
    end
    if (adv) begin
      out_event_r <= ev_code;
      out_phase_r <= ph_code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_event_r;
  assign out_fsm_phase  = out_phase_r;

`ifndef ASSERT_OFF
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input stage");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("advanced transaction did not reach the output");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r)
    else $error("staged transaction lost");
`endif

endmodule
